### rtl/dng_pkg.sv
package dng_pkg;

  // Width of the grid dimension fields.
  localparam int unsigned IN_W = 8;

  // Width of the result count, which wraps modulo 2^64.
  localparam int unsigned CNT_W = 64;

  // Default number of cells in the chain, one per grid column.
  localparam int unsigned MAX_DIM_DEF = 255;

  // Data handed from one cell to the next in every cycle.
  typedef struct packed {
    logic             vld;   // a row token is present
    logic             last;  // the token belongs to the last row
    logic [CNT_W-1:0] left;  // value just computed (left of the next cell)
    logic [CNT_W-1:0] diag;  // value of the previous row (above-left)
  } dng_link_t;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic            init;  // set the stored column value to one
    logic [IN_W-1:0] m;     // clamped column count of the current item
  } dng_ctrl_t;

endpackage

### rtl/dng_cell.sv
module dng_cell
  import dng_pkg::*;
#(
  parameter int unsigned IDX = 1
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  dng_ctrl_t ctrl_i,
  input  dng_link_t link_i,
  output dng_link_t link_o
);

  logic             vld_q;
  logic             last_q;
  logic [CNT_W-1:0] left_q;
  logic [CNT_W-1:0] diag_q;
  logic [CNT_W-1:0] val_q;
  logic [CNT_W-1:0] sum;
  logic             active;

  // A cell beyond the column count only forwards the stream toward the end.
  assign active = (int'(ctrl_i.m) >= int'(IDX));
  assign sum    = link_i.left + link_i.diag + val_q;

  // Token valid and last-row flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      last_q <= 1'b0;
    end else if (ctrl_i.init) begin
      vld_q  <= 1'b0;
      last_q <= 1'b0;
    end else begin
      vld_q  <= link_i.vld;
      last_q <= link_i.vld & link_i.last;
    end
  end

  // Column value of the latest row and the values passed to the neighbor.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.init) begin
      val_q <= CNT_W'(1);
    end else if (link_i.vld) begin
      if (active) begin
        val_q  <= sum;
        left_q <= sum;
        diag_q <= val_q;
      end else begin
        left_q <= link_i.left;
        diag_q <= link_i.diag;
      end
    end
  end

  assign link_o.vld  = vld_q;
  assign link_o.last = last_q;
  assign link_o.left = left_q;
  assign link_o.diag = diag_q;

endmodule

### rtl/delannoy_number_grid.sv
// An item with a zero dimension gives done_o in the cycle after it is accepted. One item
// is in flight at a time; the row tokens must cross the whole chain of MAX_DIM cells
// before the result is captured at the chain end.
// done_o strobes for one cycle; count_o holds the result; the receiver cannot stall it.
// Reset (rst_ni low, asynchronous) returns the sequencer to idle and drops all tokens.
module delannoy_number_grid
  import dng_pkg::*;
#(
  parameter int unsigned MAX_DIM = MAX_DIM_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic [IN_W-1:0]  rows_i,
  input  logic [IN_W-1:0]  cols_i,
  output logic             done_o,
  output logic [CNT_W-1:0] count_o
);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  state_e           state_q;
  logic [IN_W-1:0]  n_q;
  logic [IN_W-1:0]  m_q;
  logic [IN_W-1:0]  fed_q;
  logic             done_q;
  logic [CNT_W-1:0] count_q;
  logic [IN_W-1:0]  n_clamp;
  logic [IN_W-1:0]  m_clamp;
  logic             accept;
  logic             zero_dim;
  dng_ctrl_t        ctrl;
  dng_link_t        link [MAX_DIM+1];

  // Dimensions above the chain length saturate at MAX_DIM.
  assign n_clamp  = (int'(rows_i) > int'(MAX_DIM)) ? IN_W'(MAX_DIM) : rows_i;
  assign m_clamp  = (int'(cols_i) > int'(MAX_DIM)) ? IN_W'(MAX_DIM) : cols_i;
  assign accept   = start & ~busy;
  assign zero_dim = (n_clamp == '0) || (m_clamp == '0);

  assign ctrl.init = accept & ~zero_dim;
  assign ctrl.m    = m_q;

  // The feeder enters one row token per cycle; the first column is always one.
  assign link[0].vld  = (state_q == ST_RUN) && (fed_q != n_q);
  assign link[0].last = (fed_q == n_q - IN_W'(1));
  assign link[0].left = CNT_W'(1);
  assign link[0].diag = CNT_W'(1);

  // Chain of column cells, one per grid column.
  for (genvar k = 1; k <= MAX_DIM; k++) begin : g_cell
    dng_cell #(
      .IDX(k)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .ctrl_i(ctrl),
      .link_i(link[k-1]),
      .link_o(link[k])
    );
  end

  // Sequencer: feeds an item's rows, takes the chain-end result; a zero dim gives one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      n_q     <= '0;
      m_q     <= '0;
      fed_q   <= '0;
      done_q  <= 1'b0;
      count_q <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (zero_dim) begin
              done_q  <= 1'b1;
              count_q <= CNT_W'(1);
            end else begin
              n_q     <= n_clamp;
              m_q     <= m_clamp;
              fed_q   <= '0;
              state_q <= ST_RUN;
            end
          end
        end
        ST_RUN: begin
          if (link[0].vld) begin
            fed_q <= fed_q + IN_W'(1);
          end
          if (link[MAX_DIM].vld && link[MAX_DIM].last) begin
            done_q  <= 1'b1;
            count_q <= link[MAX_DIM].left;
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy    = (state_q != ST_IDLE);
  assign done_o  = done_q;
  assign count_o = count_q;

`ifndef ASSERT_OFF
  // An item with a zero dimension answers one in the next cycle.
  a_zero_dim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && zero_dim |=> done_o && (count_o == CNT_W'(1)))
    else $error("zero-dimension item did not give a count of one");

  // An item with both dimensions nonzero keeps the block busy.
  a_run_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !zero_dim |=> busy && !done_o)
    else $error("nonzero item did not start a sweep");

  // Tokens reach the chain end only while a sweep is running.
  a_tail_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    link[MAX_DIM].vld |-> busy)
    else $error("row token at the chain end while idle");

  // The feeder never enters more rows than the item has.
  a_feed_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> (fed_q <= n_q))
    else $error("more row tokens fed than rows");
`endif

endmodule

### bench/tb_delannoy_number_grid.sv
`timescale 1ns / 100ps

module tb_delannoy_number_grid;
  import dng_pkg::*;

  localparam int DIM_LIM = MAX_DIM_DEF;
  localparam int TAIL_CYCLES = 2 * DIM_LIM + 8;

  // One pending grid request and the idle gap the driver keeps before it.
  typedef struct {
    logic [IN_W-1:0] rows;
    logic [IN_W-1:0] cols;
    int unsigned     gap;
  } grid_item_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic [IN_W-1:0]  rows_i = '0;
  logic [IN_W-1:0]  cols_i = '0;
  logic             done_o;
  logic [CNT_W-1:0] count_o;

  grid_item_t       pending_items[$];
  logic [CNT_W-1:0] expected_counts[$];
  grid_item_t       next_item;
  int unsigned      hold_cnt = 0;
  int unsigned      fail_count = 0;

  // Private copy of the sweep state: one grid row and the running left cell.
  logic [CNT_W-1:0] line_buf [0:DIM_LIM];
  logic [CNT_W-1:0] left_cell = CNT_W'(1);

  delannoy_number_grid i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .rows_i  (rows_i),
    .cols_i  (cols_i),
    .done_o  (done_o),
    .count_o (count_o)
  );

  always #5 clk_i = ~clk_i;

  // Sweeps the grid row by row; every cell sums up, up-left and left, modulo 2^64.
  function automatic logic [CNT_W-1:0] delannoy_count(input logic [IN_W-1:0] n_in,
                                                      input logic [IN_W-1:0] m_in);
    int n;
    int m;
    logic [CNT_W-1:0] diag_cell;
    logic [CNT_W-1:0] up_cell;
    n = (int'(n_in) > DIM_LIM) ? DIM_LIM : int'(n_in);
    m = (int'(m_in) > DIM_LIM) ? DIM_LIM : int'(m_in);
    // A zero dimension leaves a single path and does not touch the row.
    if (n == 0 || m == 0) begin
      return CNT_W'(1);
    end
    for (int k = 0; k <= DIM_LIM; k++) begin
      line_buf[k] = CNT_W'(1);
    end
    for (int r = 1; r <= n; r++) begin
      diag_cell = line_buf[0];
      left_cell = CNT_W'(1);
      line_buf[0] = left_cell;
      for (int c = 1; c <= m; c++) begin
        up_cell = line_buf[c];
        left_cell = up_cell + diag_cell + left_cell;
        line_buf[c] = left_cell;
        diag_cell = up_cell;
      end
    end
    return line_buf[m];
  endfunction

  // Driver: presents queued items and records the expected count on acceptance.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      rows_i <= '0;
      cols_i <= '0;
      hold_cnt <= 0;
    end else if (start && !busy) begin
      expected_counts.push_back(delannoy_count(rows_i, cols_i));
      // Keep start high when the next item follows without a gap.
      if (pending_items.size() != 0 && pending_items[0].gap == 0) begin
        next_item = pending_items.pop_front();
        rows_i <= next_item.rows;
        cols_i <= next_item.cols;
      end else begin
        start <= 1'b0;
        hold_cnt <= (pending_items.size() != 0) ? pending_items[0].gap : 0;
      end
    end else if (!start) begin
      if (hold_cnt != 0) begin
        hold_cnt <= hold_cnt - 1;
      end else if (pending_items.size() != 0) begin
        next_item = pending_items.pop_front();
        rows_i <= next_item.rows;
        cols_i <= next_item.cols;
        start <= 1'b1;
      end
    end
  end

  // Monitor: every strobed result must match the oldest expected count.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_counts.size() == 0) begin
        $error("count: expected none, actual %0d", count_o);
        fail_count++;
      end else if (count_o !== expected_counts[0]) begin
        $error("count: expected %0d, actual %0d", expected_counts[0], count_o);
        fail_count++;
        void'(expected_counts.pop_front());
      end else begin
        void'(expected_counts.pop_front());
      end
    end
  end

  // Adds one item to the pending queue.
  task automatic queue_item(input int r, input int c, input bit burst);
    grid_item_t item;
    item.rows = r[IN_W-1:0];
    item.cols = c[IN_W-1:0];
    item.gap = burst ? 0 : $urandom_range(0, 9);
    pending_items.push_back(item);
  endtask

  // Picks one dimension: mostly the full range, some small, some at the edges.
  function automatic int pick_dim();
    int sel;
    int edge_sel;
    sel = $urandom_range(0, 99);
    if (sel < 60) begin
      return $urandom_range(0, 255);
    end else if (sel < 85) begin
      return $urandom_range(0, 15);
    end
    edge_sel = $urandom_range(0, 3);
    case (edge_sel)
      0: begin
        return 0;
      end
      1: begin
        return 1;
      end
      2: begin
        return 254;
      end
      default: begin
        return 255;
      end
    endcase
  endfunction

  // Stimulus and end of run.
  initial begin
    bit burst;
    burst = 1'b0;

    // Directed part: zero dimensions, extremes, swapped pairs.
    queue_item(0, 0, 1'b0);
    queue_item(0, 255, 1'b0);
    queue_item(255, 0, 1'b1);
    queue_item(0, 1, 1'b1);
    queue_item(1, 0, 1'b0);
    queue_item(1, 1, 1'b0);
    queue_item(1, 255, 1'b1);
    queue_item(255, 1, 1'b0);
    queue_item(255, 255, 1'b0);
    queue_item(2, 3, 1'b1);
    queue_item(3, 2, 1'b1);
    queue_item(1, 2, 1'b0);
    queue_item(2, 1, 1'b0);
    queue_item(5, 5, 1'b0);
    queue_item(128, 127, 1'b1);
    queue_item(127, 128, 1'b0);
    queue_item(85, 170, 1'b0);
    queue_item(170, 85, 1'b1);
    queue_item(200, 17, 1'b0);
    queue_item(17, 200, 1'b0);
    queue_item(254, 254, 1'b0);

    // Random part, with stretches of back-to-back items.
    for (int i = 0; i < 1150; i++) begin
      if ($urandom_range(0, 49) == 0) begin
        burst = ~burst;
      end
      queue_item(pick_dim(), pick_dim(), burst);
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Drain: all items sent and every expected count seen.
    while (pending_items.size() != 0 || start || expected_counts.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (expected_counts.size() != 0) begin
      $error("count: %0d expected results never arrived", expected_counts.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("delannoy_number_grid: match");
    end else begin
      $display("delannoy_number_grid: mismatch");
    end
    $finish;
  end

  // Watchdog for a hung run.
  initial begin
    #25_000_000;
    $display("delannoy_number_grid: mismatch");
    $finish;
  end

endmodule

### sim.f
rtl/dng_pkg.sv
rtl/dng_cell.sv
rtl/delannoy_number_grid.sv
bench/tb_delannoy_number_grid.sv
